// ----- design/lz77d_pkg.sv -----
// ----------------------------------------------------------------------------
// LZ77 decompressor package
// Shared constants, codes, types and helpers of the escape-coded decompressor.
// ----------------------------------------------------------------------------
package lz77d_pkg;

  localparam int HISTORY_DEPTH = 65536;
  localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
  localparam int CNT_W         = ADDR_W + 1;
  localparam int CALC_W        = 18;

  localparam logic [7:0]  ESC_BYTE  = 8'h1B;
  localparam logic [7:0]  CMD_MATCH = 8'h00;
  localparam logic [15:0] MIN_LEN   = 16'd3;

  localparam logic OP_FEED  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_REFUSED   = 3'd1,
    ST_ENDED     = 3'd2,
    ST_BAD_MATCH = 3'd3,
    ST_UNKNOWN   = 3'd4,
    ST_TRUNCATED = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    PH_PLAIN   = 3'd0,
    PH_CMD     = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_OFF_LO  = 3'd4,
    PH_OFF_HI  = 3'd5
  } phase_t;

  typedef struct packed {
    logic              byte_valid;
    logic              from_mem;
    logic              fwd;
    logic [7:0]        fwd_data;
    logic [7:0]        lit;
    logic              copy_last;
    status_t           status;
    logic              wr;
    logic [ADDR_W-1:0] wr_addr;
  } stage_t;

  function automatic logic [ADDR_W-1:0] wrap_next(input logic [ADDR_W-1:0] p);
    return (p == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

// ----- design/lz77d_ram.sv -----
// ----------------------------------------------------------------------------
// LZ77 decompressor history RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module lz77d_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/lz77_escape_stream_decompressor.sv -----
// ----------------------------------------------------------------------------
// Escape-coded LZ77 stream decompressor
// Parses the compressed byte stream and drains match copies from the history.
// ----------------------------------------------------------------------------
// One word is accepted in every cycle unless the output stalls; its result
// word appears in the cycle after, and back-to-back words are sustained as
// the history RAM has a separate read and write port and the byte being
// written by the previous word is forwarded to a read of the same entry.
// The history needs no clearing pass after reset: only produced bytes are read.
module lz77_escape_stream_decompressor
  import lz77d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       opcode,
  input  logic [7:0] in_byte,
  input  logic       stream_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       byte_valid,
  output logic [7:0] out_byte,
  output logic       copy_last,
  output logic [2:0] status
);

  phase_t            phase, phase_next;
  logic [15:0]       match_length, match_length_next;
  logic [15:0]       match_offset, match_offset_next;
  logic [ADDR_W-1:0] write_pointer, write_pointer_next;
  logic [CNT_W-1:0]  produced_count, produced_count_next;
  logic [15:0]       copy_remaining, copy_remaining_next;
  logic [ADDR_W-1:0] copy_read_pointer, copy_read_pointer_next;
  status_t           sticky, sticky_next;

  logic              s1_valid;
  stage_t            s1, s1_next;

  logic              en;
  logic              accept;
  logic              rd_en;
  logic              record;
  logic [7:0]        rd_data;
  logic [7:0]        s1_data;
  logic [15:0]       off_full;
  logic [CALC_W-1:0] wp_ext, off_ext, diff;

  assign in_stall = s1_valid && out_stall;
  assign en       = !in_stall;
  assign accept   = in_valid && en;

  assign s1_data = !s1.byte_valid ? 8'h00 :
                   s1.from_mem ? (s1.fwd ? s1.fwd_data : rd_data) : s1.lit;

  assign out_valid  = s1_valid;
  assign byte_valid = s1.byte_valid;
  assign out_byte   = s1_data;
  assign copy_last  = s1.copy_last;
  assign status     = s1.status;

  lz77d_ram #(
    .DEPTH(HISTORY_DEPTH),
    .AW   (ADDR_W),
    .DW   (8)
  ) u_hist (
    .clk  (clk),
    .we   (s1_valid && en && s1.wr),
    .waddr(s1.wr_addr),
    .wdata(s1_data),
    .re   (rd_en),
    .raddr(copy_read_pointer),
    .rdata(rd_data)
  );

  always_comb begin
    phase_next             = phase;
    match_length_next      = match_length;
    match_offset_next      = match_offset;
    write_pointer_next     = write_pointer;
    produced_count_next    = produced_count;
    copy_remaining_next    = copy_remaining;
    copy_read_pointer_next = copy_read_pointer;
    sticky_next            = sticky;
    record                 = 1'b0;
    rd_en                  = 1'b0;
    off_full               = {in_byte, match_offset[7:0]};
    wp_ext                 = CALC_W'(write_pointer);
    off_ext                = CALC_W'(off_full);
    diff                   = wp_ext - off_ext;
    s1_next                = '0;
    s1_next.status         = sticky;
    s1_next.wr_addr        = write_pointer;
    s1_next.lit            = in_byte;

    if (sticky != ST_OK) begin
      s1_next.status = sticky;
    end else if (opcode == OP_DRAIN) begin
      if (copy_remaining != 16'd0) begin
        rd_en                  = accept;
        record                 = 1'b1;
        s1_next.byte_valid     = 1'b1;
        s1_next.from_mem       = 1'b1;
        s1_next.fwd            = s1_valid && s1.wr && (s1.wr_addr == copy_read_pointer);
        s1_next.fwd_data       = s1_data;
        s1_next.copy_last      = (copy_remaining == 16'd1);
        s1_next.status         = ST_OK;
        copy_read_pointer_next = wrap_next(copy_read_pointer);
        copy_remaining_next    = copy_remaining - 16'd1;
      end
    end else if (copy_remaining != 16'd0) begin
      s1_next.status = ST_REFUSED;
    end else begin
      case (phase)
        PH_PLAIN: begin
          if (in_byte != ESC_BYTE) begin
            record             = 1'b1;
            s1_next.byte_valid = 1'b1;
          end else begin
            phase_next = PH_CMD;
            if (stream_last) sticky_next = ST_TRUNCATED;
          end
        end
        PH_CMD: begin
          if (in_byte == ESC_BYTE) begin
            phase_next         = PH_PLAIN;
            record             = 1'b1;
            s1_next.byte_valid = 1'b1;
          end else if (in_byte == CMD_MATCH) begin
            phase_next = PH_LEN_LO;
            if (stream_last) sticky_next = ST_TRUNCATED;
          end else begin
            phase_next  = PH_PLAIN;
            sticky_next = ST_UNKNOWN;
          end
        end
        PH_LEN_LO: begin
          match_length_next = {8'h00, in_byte};
          phase_next        = PH_LEN_HI;
          if (stream_last) sticky_next = ST_TRUNCATED;
        end
        PH_LEN_HI: begin
          match_length_next = {in_byte, match_length[7:0]};
          phase_next        = PH_OFF_LO;
          if (stream_last) sticky_next = ST_TRUNCATED;
        end
        PH_OFF_LO: begin
          match_offset_next = {8'h00, in_byte};
          phase_next        = PH_OFF_HI;
          if (stream_last) sticky_next = ST_TRUNCATED;
        end
        PH_OFF_HI: begin
          match_offset_next = off_full;
          phase_next        = PH_PLAIN;
          if (match_length == 16'd0 && off_full == 16'd0) begin
            sticky_next = ST_ENDED;
          end else if (match_length < MIN_LEN || off_full == 16'd0 ||
                       off_ext > CALC_W'(produced_count)) begin
            sticky_next = ST_BAD_MATCH;
          end else begin
            copy_remaining_next = match_length;
            if (off_ext <= wp_ext) begin
              copy_read_pointer_next = diff[ADDR_W-1:0];
            end else begin
              copy_read_pointer_next = ADDR_W'(diff + CALC_W'(HISTORY_DEPTH));
            end
          end
        end
        default: begin
          phase_next = PH_PLAIN;
        end
      endcase
      if (!s1_next.byte_valid) s1_next.status = sticky_next;
      else                     s1_next.status = ST_OK;
    end

    if (record) begin
      s1_next.wr         = 1'b1;
      write_pointer_next = wrap_next(write_pointer);
      if (produced_count != CNT_W'(HISTORY_DEPTH)) begin
        produced_count_next = produced_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_PLAIN;
      match_length      <= '0;
      match_offset      <= '0;
      write_pointer     <= '0;
      produced_count    <= '0;
      copy_remaining    <= '0;
      copy_read_pointer <= '0;
      sticky            <= ST_OK;
      s1_valid          <= 1'b0;
    end else begin
      if (accept) begin
        phase             <= phase_next;
        match_length      <= match_length_next;
        match_offset      <= match_offset_next;
        write_pointer     <= write_pointer_next;
        produced_count    <= produced_count_next;
        copy_remaining    <= copy_remaining_next;
        copy_read_pointer <= copy_read_pointer_next;
        sticky            <= sticky_next;
      end
      if (en) begin
        s1_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
  end

endmodule

// ----- tb/lz77d_stream_checker.sv -----
// ----------------------------------------------------------------------------
// LZ77 decompressor stream checker
// Watches both channels of the decompressor, predicts the result word of every
// accepted input word from its own model of the parser, history and copy
// engine, and compares each accepted result word with the oldest prediction.
// ----------------------------------------------------------------------------
module lz77d_stream_checker
  import lz77d_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              opcode,
  input  logic [7:0]        in_byte,
  input  logic              stream_last,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              byte_valid,
  input  logic [7:0]        out_byte,
  input  logic              copy_last,
  input  logic [2:0]        status,
  output int unsigned       fail_count,
  output int unsigned       awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] data;
    logic       copy_last;
    status_t    status;
  } result_t;

  result_t     decoded_words[$];
  int unsigned errs = 0;

  phase_t      phase;
  status_t     sticky;
  logic [15:0] m_len;
  logic [15:0] m_off;
  int          wr_ptr;
  int          rd_ptr;
  int          produced;
  int          copy_left;
  bit   [7:0]  history [HISTORY_DEPTH];

  task automatic keep_byte(input logic [7:0] b);
    history[wr_ptr] = b;
    wr_ptr = (wr_ptr + 1) % HISTORY_DEPTH;
    if (produced < HISTORY_DEPTH) produced++;
  endtask

  task automatic decode_step(input logic op, input logic [7:0] b, input logic last,
                             output result_t r);
    logic [7:0] v;
    r.byte_valid = 1'b0;
    r.data = 8'h00;
    r.copy_last = 1'b0;
    r.status = sticky;
    if (sticky != ST_OK) return;
    if (op == OP_DRAIN) begin
      if (copy_left == 0) return;
      v = history[rd_ptr];
      rd_ptr = (rd_ptr + 1) % HISTORY_DEPTH;
      keep_byte(v);
      copy_left--;
      r.byte_valid = 1'b1;
      r.data = v;
      r.copy_last = (copy_left == 0);
      r.status = ST_OK;
      return;
    end
    if (copy_left != 0) begin
      r.status = ST_REFUSED;
      return;
    end
    case (phase)
      PH_PLAIN: begin
        if (b != ESC_BYTE) begin
          keep_byte(b);
          r.byte_valid = 1'b1;
          r.data = b;
          return;
        end
        phase = PH_CMD;
        if (last) sticky = ST_TRUNCATED;
      end
      PH_CMD: begin
        if (b == ESC_BYTE) begin
          phase = PH_PLAIN;
          keep_byte(ESC_BYTE);
          r.byte_valid = 1'b1;
          r.data = ESC_BYTE;
          return;
        end
        if (b == CMD_MATCH) begin
          phase = PH_LEN_LO;
          if (last) sticky = ST_TRUNCATED;
        end else begin
          phase = PH_PLAIN;
          sticky = ST_UNKNOWN;
        end
      end
      PH_LEN_LO: begin
        m_len = {8'h00, b};
        phase = PH_LEN_HI;
        if (last) sticky = ST_TRUNCATED;
      end
      PH_LEN_HI: begin
        m_len[15:8] = b;
        phase = PH_OFF_LO;
        if (last) sticky = ST_TRUNCATED;
      end
      PH_OFF_LO: begin
        m_off = {8'h00, b};
        phase = PH_OFF_HI;
        if (last) sticky = ST_TRUNCATED;
      end
      default: begin
        m_off[15:8] = b;
        phase = PH_PLAIN;
        if (m_len == 16'd0 && m_off == 16'd0) begin
          sticky = ST_ENDED;
        end else if (m_len < MIN_LEN || m_off == 16'd0 || int'(m_off) > produced) begin
          sticky = ST_BAD_MATCH;
        end else begin
          rd_ptr = (wr_ptr + HISTORY_DEPTH - int'(m_off)) % HISTORY_DEPTH;
          copy_left = int'(m_len);
        end
      end
    endcase
    r.status = sticky;
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    result_t fresh;
    if (rst) begin
      phase = PH_PLAIN;
      sticky = ST_OK;
      m_len = '0;
      m_off = '0;
      wr_ptr = 0;
      rd_ptr = 0;
      produced = 0;
      copy_left = 0;
      decoded_words.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_words.size() == 0) begin
          $error("Result word arrived with no prediction waiting.");
          errs++;
        end else begin
          want = decoded_words.pop_front();
          if (byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0d, got %0d", want.byte_valid, byte_valid);
            errs++;
          end
          if (out_byte !== want.data) begin
            $error("out_byte: expected %0d, got %0d", want.data, out_byte);
            errs++;
          end
          if (copy_last !== want.copy_last) begin
            $error("copy_last: expected %0d, got %0d", want.copy_last, copy_last);
            errs++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        decode_step(opcode, in_byte, stream_last, fresh);
        decoded_words = {decoded_words, fresh};
      end
    end
    awaited <= decoded_words.size();
    fail_count <= errs;
  end

endmodule

// ----- tb/lz77_escape_stream_decompressor_tb.sv -----
// ----------------------------------------------------------------------------
// LZ77 decompressor testbench
// Feeds the decompressor directed and random escape-coded streams with random
// gaps on the input and random stalls on the output, and ends each run on one
// terminating condition whose status must then stick.
// ----------------------------------------------------------------------------
module lz77_escape_stream_decompressor_tb
  import lz77d_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          HALF_PERIOD = 5;
  localparam int          RESET_CYCLES = 7;
  localparam int          RANDOM_WORDS = 1750;
  localparam int          TAIL_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef enum int {
    STOP_MARKER,
    STOP_SHORT,
    STOP_ZERO_OFFSET,
    STOP_FAR_OFFSET,
    STOP_UNKNOWN,
    STOP_CUT
  } stop_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        opcode = OP_FEED;
  logic [7:0]  in_byte = 8'h00;
  logic        stream_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        byte_valid;
  logic [7:0]  out_byte;
  logic        copy_last;
  logic [2:0]  status;
  int unsigned fail_count;
  int unsigned awaited;

  int unsigned cycles = 0;
  int          hold_left = 0;
  logic        stall_on = 1'b1;
  logic        feed_idle = 1'b1;
  int          made = 0;
  int          words_sent = 0;

  lz77_escape_stream_decompressor i_dut (.*);

  lz77d_stream_checker i_checker (.*);

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin : result_side
    int n;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (out_valid && !out_stall) begin
      n = stall_on ? $urandom_range(0, 3) : 0;
      hold_left <= n;
      out_stall <= (n != 0);
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end
  end

  task automatic send_word(input logic op, input logic [7:0] b, input logic last);
    int gap;
    gap = feed_idle ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    in_byte <= b;
    stream_last <= last;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic drain_word();
    send_word(OP_DRAIN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_plain(input logic [7:0] b, input logic last);
    send_word(OP_FEED, b, last);
    if (made < HISTORY_DEPTH) made++;
  endtask

  task automatic send_header(input logic [15:0] len, input logic [15:0] off,
                             input logic last);
    send_word(OP_FEED, ESC_BYTE, 1'b0);
    send_word(OP_FEED, CMD_MATCH, 1'b0);
    send_word(OP_FEED, len[7:0], 1'b0);
    send_word(OP_FEED, len[15:8], 1'b0);
    send_word(OP_FEED, off[7:0], 1'b0);
    send_word(OP_FEED, off[15:8], last);
  endtask

  task automatic send_match(input logic [15:0] len, input logic [15:0] off,
                            input logic last, input bit noisy);
    send_header(len, off, last);
    for (int i = 0; i < int'(len); i++) begin
      if (noisy && $urandom_range(0, 9) == 0)
        send_word(OP_FEED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      drain_word();
    end
    made = (made + int'(len) > HISTORY_DEPTH) ? HISTORY_DEPTH : made + int'(len);
  endtask

  function automatic int reach();
    return (made > 65535) ? 65535 : made;
  endfunction

  initial begin
    stop_kind_t  stop_kind;
    int          target;
    int          pick;
    int          len;
    int          off;
    int          cut_at;
    logic [7:0]  b;
    logic [7:0]  cut_seq [5];

    stop_kind = stop_kind_t'($urandom_range(0, 5));
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    send_word(OP_DRAIN, 8'hFF, 1'b1);
    send_plain(8'h00, 1'b0);
    send_plain(8'hFF, 1'b0);
    send_plain(8'h5A, 1'b1);
    send_word(OP_FEED, ESC_BYTE, 1'b0);
    send_plain(ESC_BYTE, 1'b1);
    send_header(16'd4, 16'd1, 1'b1);
    send_word(OP_FEED, ESC_BYTE, 1'b1);
    repeat (4) drain_word();
    made += 4;
    send_match(16'd3, 16'(made), 1'b0, 1'b0);
    send_word(OP_DRAIN, 8'h00, 1'b0);

    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      if ($urandom_range(0, 15) == 0) feed_idle = ~feed_idle;
      if ($urandom_range(0, 15) == 0) stall_on <= ~stall_on;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        do b = 8'($urandom_range(0, 255)); while (b == ESC_BYTE);
        send_plain(b, 1'($urandom_range(0, 19) == 0));
      end else if (pick < 55) begin
        send_word(OP_FEED, ESC_BYTE, 1'b0);
        send_plain(ESC_BYTE, 1'($urandom_range(0, 19) == 0));
      end else if (pick < 90) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 600) : $urandom_range(3, 16);
        case ($urandom_range(0, 2))
          0:       off = $urandom_range(1, (len < reach()) ? len : reach());
          1:       off = reach();
          default: off = $urandom_range(1, reach());
        endcase
        send_match(16'(len), 16'(off), 1'($urandom_range(0, 19) == 0), 1'b1);
      end else begin
        drain_word();
      end
    end

    feed_idle = 1'b1;
    stall_on <= 1'b1;
    case (stop_kind)
      STOP_MARKER:
        send_header(16'h0000, 16'h0000, 1'($urandom_range(0, 1)));
      STOP_SHORT:
        send_header(16'($urandom_range(0, 2)), 16'($urandom_range(1, reach())),
                    1'($urandom_range(0, 1)));
      STOP_ZERO_OFFSET:
        send_header(16'($urandom_range(int'(MIN_LEN), 65535)), 16'h0000,
                    1'($urandom_range(0, 1)));
      STOP_FAR_OFFSET:
        send_header(16'($urandom_range(3, 64)), 16'($urandom_range(made + 1, 65535)),
                    1'($urandom_range(0, 1)));
      STOP_UNKNOWN: begin
        send_word(OP_FEED, ESC_BYTE, 1'b0);
        do b = 8'($urandom_range(0, 255)); while (b == ESC_BYTE || b == CMD_MATCH);
        send_word(OP_FEED, b, 1'($urandom_range(0, 1)));
      end
      default: begin
        cut_seq[0] = ESC_BYTE;
        cut_seq[1] = CMD_MATCH;
        for (int i = 2; i < 5; i++) cut_seq[i] = 8'($urandom_range(0, 255));
        cut_at = $urandom_range(0, 4);
        for (int i = 0; i <= cut_at; i++) send_word(OP_FEED, cut_seq[i], 1'(i == cut_at));
      end
    endcase
    repeat (12)
      send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    in_valid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/lz77d_pkg.sv
design/lz77d_ram.sv
design/lz77_escape_stream_decompressor.sv
tb/lz77d_stream_checker.sv
tb/lz77_escape_stream_decompressor_tb.sv
